>>> hdl/pmcu_pkg.sv
// ----------------------------------------------------------------------------
// pmcu_pkg: shared types and constants for the program memory block
// Item kinds, result kinds and the command record passed front to back.
// ----------------------------------------------------------------------------
package pmcu_pkg;

  localparam logic [2:0] KIND_POLL  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_MAP   = 3'd2;
  localparam logic [2:0] KIND_CHUNK = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  localparam logic [1:0] OUT_DATA   = 2'd0;
  localparam logic [1:0] OUT_INSTR  = 2'd1;
  localparam logic [1:0] OUT_STATUS = 2'd2;
  localparam logic [1:0] OUT_MAP    = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic        write_req;
    logic        hold;
    logic [15:0] instr_addr;
    logic [15:0] data_addr;
    logic [7:0]  data_in;
    logic [2:0]  map_index;
    logic [7:0]  chunk_sel;
    logic [7:0]  word_offset;
    logic [31:0] payload;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_START_OUT, ST_POLL_RD, ST_POLL_DATA, ST_POLL_INSTR,
    ST_CHUNK_RD, ST_CHUNK_WR, ST_END_STATUS, ST_END_MAP
  } back_state_t;

endpackage

>>> hdl/pmcu_front.sv
// ----------------------------------------------------------------------------
// pmcu_front: input stage and command queue
// Accepts items, drops unused kinds and buffers two commands for the back end.
// ----------------------------------------------------------------------------
module pmcu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pmcu_pkg::cmd_t in_cmd,
  output logic           q_valid,
  input  logic           q_pop,
  output pmcu_pkg::cmd_t q_cmd
);
  import pmcu_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  // Unused kinds are taken and discarded here.
  assign push = in_valid && in_ready && (in_cmd.kind <= KIND_END);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

>>> hdl/pmcu_back.sv
// ----------------------------------------------------------------------------
// pmcu_back: command execution
// Owns both stores and the pending map and produces the result beats.
// ----------------------------------------------------------------------------
module pmcu_back #(
  parameter int INSTR_WORDS = 65536,
  parameter int DMEM_DEPTH  = 256,
  parameter int CHUNK_COUNT = 256,
  parameter int CHUNK_WORDS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  pmcu_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [31:0]    out_value,
  output logic [2:0]     out_index,
  output logic           out_last,
  output logic           busy
);
  import pmcu_pkg::*;

  localparam int IAW = $clog2(INSTR_WORDS);
  localparam int DAW = $clog2(DMEM_DEPTH);
  localparam int MAP_USED = (CHUNK_COUNT + 31) / 32;
  localparam int CLR_W = (IAW > DAW) ? IAW : DAW;
  localparam logic [CLR_W:0] CLR_END = (INSTR_WORDS > DMEM_DEPTH) ?
      (CLR_W + 1)'(INSTR_WORDS) : (CLR_W + 1)'(DMEM_DEPTH);

  logic [31:0] imem [INSTR_WORDS];
  logic [7:0]  dmem [DMEM_DEPTH];

  back_state_t st_r, st_nxt;
  cmd_t        c_r;
  logic [31:0] map_r [8];
  logic        active_r, valid_r, prev_hold_r, acc_r;
  logic        boot_r;
  logic [7:0]  last_d_r;
  logic [31:0] last_i_r;
  logic [CLR_W:0] clr_r;
  logic [2:0]  mi_r;
  logic [31:0] irdd_r, irdi_r;
  logic [7:0]  drd_r;
  logic        drange_r, irange_r, ddrange_r, wr_hit_r;
  logic        ov_r, ol_r;
  logic [1:0]  ok_r;
  logic [31:0] oval_r;
  logic [2:0]  oi_r;

  logic        out_free, d_in_rng, i_in_rng, cidx_ok, pend_bit, ready_all;
  logic [7:0]  db;
  logic [31:0] iw;
  logic [31:0] caddr;
  logic        cwr, dwr, ov_set;

  assign out_valid = ov_r;
  assign out_kind  = ok_r;
  assign out_value = oval_r;
  assign out_index = oi_r;
  assign out_last  = ol_r;
  assign out_free  = !ov_r || out_ready;
  assign busy      = (st_r != ST_IDLE) || ov_r;

  assign d_in_rng = {16'd0, c_r.data_addr} < DMEM_DEPTH;
  assign i_in_rng = {16'd0, c_r.instr_addr} < INSTR_WORDS;
  // The data read in POLL_RD still returns the old byte, so a write made in
  // that same cycle is forwarded from the command.
  assign db = ddrange_r ? (wr_hit_r ? c_r.data_in : drd_r) :
              (drange_r ? irdd_r[7:0] : 8'd0);
  assign iw = irange_r ? irdi_r : 32'd0;
  assign cidx_ok = {24'd0, c_r.chunk_sel} < CHUNK_COUNT;
  assign pend_bit = map_r[c_r.chunk_sel[7:5]][c_r.chunk_sel[4:0]];
  assign caddr = 32'(c_r.chunk_sel) * 32'(CHUNK_WORDS) + {24'd0, c_r.word_offset};

  always_comb begin
    ready_all = 1'b1;
    for (int i = 0; i < MAP_USED; i++) begin
      if ((32'(CHUNK_COUNT) - 32'(i * 32)) >= 32) begin
        if (map_r[i] != 32'd0) ready_all = 1'b0;
      end else begin
        if ((map_r[i] & ((32'd1 << (CHUNK_COUNT - i * 32)) - 32'd1)) != 32'd0)
          ready_all = 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) begin
        unique case (q_cmd.kind)
          KIND_START: st_nxt = ST_CLEAR;
          KIND_POLL:  st_nxt = ST_POLL_RD;
          KIND_CHUNK: st_nxt = ST_CHUNK_RD;
          KIND_END:   st_nxt = ST_END_STATUS;
          default:    st_nxt = ST_IDLE;
        endcase
      end
      ST_CLEAR:      if (clr_r + 1'b1 == CLR_END) st_nxt = boot_r ? ST_IDLE : ST_START_OUT;
      ST_START_OUT:  if (out_free) st_nxt = ST_IDLE;
      ST_POLL_RD:    st_nxt = ST_POLL_DATA;
      ST_POLL_DATA:  if (out_free) st_nxt = ST_POLL_INSTR;
      ST_POLL_INSTR: if (out_free) st_nxt = ST_IDLE;
      ST_CHUNK_RD:   st_nxt = ST_CHUNK_WR;
      ST_CHUNK_WR:   st_nxt = ST_IDLE;
      ST_END_STATUS: if (out_free) st_nxt = ST_END_MAP;
      ST_END_MAP:    if (out_free && mi_r == 3'(MAP_USED - 1)) st_nxt = ST_IDLE;
      default:       st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    q_pop = (st_r == ST_IDLE) && q_valid;
    cwr = (st_r == ST_CHUNK_WR) && (c_r.word_offset == 8'd0 ? (cidx_ok && pend_bit) : acc_r)
          && ({24'd0, c_r.word_offset} < CHUNK_WORDS) && (caddr < INSTR_WORDS);
    dwr = (st_r == ST_POLL_RD) && c_r.write_req && c_r.hold && !prev_hold_r && d_in_rng;
    ov_set = out_free && ((st_r == ST_START_OUT) ||
                          (st_r == ST_POLL_DATA && db != last_d_r) ||
                          (st_r == ST_POLL_INSTR && active_r && iw != last_i_r) ||
                          (st_r == ST_END_STATUS) || (st_r == ST_END_MAP));
  end

  // Stores: one write port, registered reads.
  always_ff @(posedge clk) begin
    if (st_r == ST_CLEAR) begin
      if (clr_r < INSTR_WORDS) imem[clr_r[IAW-1:0]] <= 32'd0;
    end else if (cwr) begin
      imem[caddr[IAW-1:0]] <= c_r.payload;
    end
    irdd_r <= imem[c_r.data_addr[IAW-1:0]];
    irdi_r <= imem[c_r.instr_addr[IAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_CLEAR) begin
      if (clr_r < DMEM_DEPTH) dmem[clr_r[DAW-1:0]] <= 8'd0;
    end else if (dwr) begin
      dmem[c_r.data_addr[DAW-1:0]] <= c_r.data_in;
    end
    drd_r <= dmem[c_r.data_addr[DAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_pop) c_r <= q_cmd;
    if (st_r == ST_POLL_RD) begin
      drange_r  <= ({16'd0, c_r.data_addr} < INSTR_WORDS);
      ddrange_r <= d_in_rng;
      irange_r  <= i_in_rng;
      wr_hit_r  <= dwr;
    end
  end

  // After reset the stores are swept to zero before the first command runs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
      boot_r <= 1'b1;
      for (int i = 0; i < 8; i++) map_r[i] <= '1;
      active_r <= 1'b0; valid_r <= 1'b0; prev_hold_r <= 1'b0; acc_r <= 1'b0;
      last_d_r <= 8'd0; last_i_r <= 32'd0;
      clr_r <= '0; mi_r <= 3'd0;
      ov_r <= 1'b0; ol_r <= 1'b0; ok_r <= OUT_DATA; oval_r <= 32'd0; oi_r <= 3'd0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_set || (ov_r && !out_ready);
      unique case (st_r)
        ST_IDLE: begin
          clr_r <= '0;
          mi_r <= 3'd0;
          if (q_valid && q_cmd.kind == KIND_MAP && {29'd0, q_cmd.map_index} < MAP_USED)
            map_r[q_cmd.map_index] <= q_cmd.payload;
        end
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r + 1'b1 == CLR_END) boot_r <= 1'b0;
          if (!boot_r) begin
            active_r <= 1'b0; valid_r <= 1'b1; acc_r <= 1'b0;
          end
        end
        ST_START_OUT: if (out_free) begin
          ok_r <= OUT_INSTR; oval_r <= 32'd0; oi_r <= 3'd0; ol_r <= 1'b1;
        end
        ST_POLL_RD: prev_hold_r <= c_r.write_req && c_r.hold;
        ST_POLL_DATA: if (out_free && db != last_d_r) begin
          last_d_r <= db;
          ok_r <= OUT_DATA; oval_r <= {24'd0, db}; oi_r <= 3'd0;
          ol_r <= !(active_r && iw != last_i_r);
        end
        ST_POLL_INSTR: if (out_free && active_r && iw != last_i_r) begin
          last_i_r <= iw;
          ok_r <= OUT_INSTR; oval_r <= iw;
          oi_r <= 3'd0; ol_r <= 1'b1;
        end
        ST_CHUNK_RD: ;
        ST_CHUNK_WR: if (c_r.word_offset == 8'd0) begin
          if (cidx_ok && pend_bit) begin
            map_r[c_r.chunk_sel[7:5]][c_r.chunk_sel[4:0]] <= 1'b0;
            acc_r <= 1'b1;
          end else begin
            valid_r <= 1'b0; acc_r <= 1'b0;
          end
        end
        ST_END_STATUS: if (out_free) begin
          if (ready_all && valid_r) active_r <= 1'b1;
          ok_r <= OUT_STATUS; oval_r <= {31'd0, valid_r}; oi_r <= 3'd0;
          ol_r <= 1'b0;
        end
        ST_END_MAP: if (out_free) begin
          ok_r <= OUT_MAP; oval_r <= map_r[mi_r]; oi_r <= mi_r;
          ol_r <= (mi_r == 3'(MAP_USED - 1));
          mi_r <= mi_r + 3'd1;
        end
        default: ;
      endcase
    end
  end
endmodule

>>> hdl/program_memory_with_chunk_upload.sv
// ----------------------------------------------------------------------------
// program_memory_with_chunk_upload: CPU program/data memory with chunk upload
// Front queue plus execution back end; each store has one write port.
// ----------------------------------------------------------------------------
// After reset the block first sweeps both stores to zero, one address a cycle,
// before it runs any item. One item at a time is executed, and an upload
// start sweeps the stores again. Each result beat adds the cycles that
// the receiver holds off. A two-entry queue keeps taking items, until both
// entries are full, while the back end works or the output is stalled.
// Result beats carry the result kind in out_tuser, and out_tlast marks the
// final beat that an item causes.
module program_memory_with_chunk_upload #(
  parameter int INSTR_WORDS = 65536,
  parameter int DMEM_DEPTH  = 256,
  parameter int CHUNK_COUNT = 256,
  parameter int CHUNK_WORDS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,   // kind
  // write_req, hold, instr_addr, data_addr, data_in, map_index, chunk_sel,
  // word_offset, payload; 3 unused bits on top
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // out_kind
  output logic [39:0]  out_tdata,  // out_value, out_index, 5 zero bits on top
  output logic         out_tlast
);
  import pmcu_pkg::*;

  cmd_t        in_cmd, q_cmd;
  logic        q_valid, q_pop, busy;
  logic [31:0] ov;
  logic [2:0]  oi;

  assign in_cmd.kind        = in_tuser;
  assign in_cmd.write_req   = in_tdata[0];
  assign in_cmd.hold        = in_tdata[1];
  assign in_cmd.instr_addr  = in_tdata[17:2];
  assign in_cmd.data_addr   = in_tdata[33:18];
  assign in_cmd.data_in     = in_tdata[41:34];
  assign in_cmd.map_index   = in_tdata[44:42];
  assign in_cmd.chunk_sel   = in_tdata[52:45];
  assign in_cmd.word_offset = in_tdata[60:53];
  assign in_cmd.payload     = in_tdata[92:61];

  pmcu_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd,
    .q_valid, .q_pop, .q_cmd
  );

  pmcu_back #(
    .INSTR_WORDS(INSTR_WORDS), .DMEM_DEPTH(DMEM_DEPTH),
    .CHUNK_COUNT(CHUNK_COUNT), .CHUNK_WORDS(CHUNK_WORDS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_kind(out_tuser),
    .out_value(ov), .out_index(oi), .out_last(out_tlast), .busy
  );

  assign out_tdata = {5'd0, oi, ov};

  a_pop_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> busy) else $error("busy low with pending beat");
endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for program_memory_with_chunk_upload
// Beats are driven from a queue of pending items and predicted at acceptance.
// Result beats are compared in order against the predicted results. The
// stimulus covers bus polls, well-formed and broken uploads, and noise, with
// random gaps on both sides of the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pmcu_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int LONG_STALL  = 500;
  localparam int MAP_WORDS   = 8;

  typedef struct {
    cmd_t c;
    bit   drain;
    bit   big_stall;
  } pending_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [2:0]  index;
    logic        last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [39:0] out_tdata;
  logic        out_tlast;

  program_memory_with_chunk_upload uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always #10 clk = ~clk;

  // Predicted block state.
  logic [31:0] instr_mem [int];
  logic [7:0]  data_mem [256];
  logic [31:0] chunk_pending [MAP_WORDS];
  bit          prog_active, prog_valid, hold_prev, chunk_ok;
  logic [7:0]  data_shown;
  logic [31:0] instr_shown;

  pending_t    pending_items[$];
  beat_t       expected_beats[$];
  int          error_count = 0;
  int          cycle_count = 0;
  logic [15:0] loaded_addrs[$];

  function automatic logic [31:0] instr_at(logic [15:0] a);
    return instr_mem.exists(int'(a)) ? instr_mem[int'(a)] : 32'h0;
  endfunction

  function automatic void add_beat(logic [1:0] k, logic [31:0] v, logic [2:0] i);
    beat_t b;
    b.kind = k; b.value = v; b.index = i; b.last = 1'b0;
    expected_beats.push_back(b);
  endfunction

  task automatic predict_item(cmd_t c);
    int          n_before;
    logic [7:0]  db;
    logic [31:0] iw;
    logic [31:0] bit_mask;
    int          w;
    bit          ready;
    n_before = expected_beats.size();
    case (c.kind)
      KIND_POLL: begin
        if (c.write_req) begin
          if (c.hold && !hold_prev && c.data_addr < 256) data_mem[c.data_addr[7:0]] = c.data_in;
          hold_prev = c.hold;
        end else begin
          hold_prev = 1'b0;
        end
        iw = instr_at(c.data_addr);
        db = (c.data_addr < 256) ? data_mem[c.data_addr[7:0]] : iw[7:0];
        if (db != data_shown) begin
          add_beat(OUT_DATA, {24'h0, db}, 3'd0);
          data_shown = db;
        end
        if (prog_active) begin
          iw = instr_at(c.instr_addr);
          if (iw != instr_shown) begin
            add_beat(OUT_INSTR, iw, 3'd0);
            instr_shown = iw;
          end
        end
      end
      KIND_START: begin
        prog_active = 1'b0;
        prog_valid = 1'b1;
        chunk_ok = 1'b0;
        instr_mem.delete();
        foreach (data_mem[i]) data_mem[i] = 8'h0;
        add_beat(OUT_INSTR, 32'h0, 3'd0);
      end
      KIND_MAP: chunk_pending[c.map_index] = c.payload;
      KIND_CHUNK: begin
        if (c.word_offset == 0) begin
          w = int'(c.chunk_sel[7:5]);
          bit_mask = 32'h1 << c.chunk_sel[4:0];
          if ((chunk_pending[w] & bit_mask) != 0) begin
            chunk_pending[w] &= ~bit_mask;
            chunk_ok = 1'b1;
          end else begin
            prog_valid = 1'b0;
            chunk_ok = 1'b0;
          end
        end
        if (chunk_ok) instr_mem[int'({c.chunk_sel, c.word_offset})] = c.payload;
      end
      KIND_END: begin
        ready = 1'b1;
        foreach (chunk_pending[i]) if (chunk_pending[i] != 0) ready = 1'b0;
        if (ready && prog_valid) prog_active = 1'b1;
        add_beat(OUT_STATUS, {31'h0, prog_valid}, 3'd0);
        foreach (chunk_pending[i]) add_beat(OUT_MAP, chunk_pending[i], 3'(i));
      end
      default: ;
    endcase
    if (expected_beats.size() > n_before) expected_beats[$].last = 1'b1;
  endtask

  // Stimulus builders.
  function automatic cmd_t blank(logic [2:0] k);
    cmd_t c;
    c = '0;
    c.kind = k;
    return c;
  endfunction

  task automatic push_cmd(cmd_t c, bit big_stall = 1'b0);
    pending_t p;
    p.c = c; p.drain = 1'b0; p.big_stall = big_stall;
    pending_items.push_back(p);
  endtask

  task automatic push_drain();
    pending_t p;
    p.c = '0; p.drain = 1'b1; p.big_stall = 1'b0;
    pending_items.push_back(p);
  endtask

  task automatic push_poll(bit wr, bit hd, logic [15:0] ia, logic [15:0] da,
                           logic [7:0] din, bit big_stall = 1'b0);
    cmd_t c;
    c = blank(KIND_POLL);
    c.write_req = wr; c.hold = hd; c.instr_addr = ia; c.data_addr = da; c.data_in = din;
    c.payload = $urandom;
    push_cmd(c, big_stall);
  endtask

  task automatic push_map(logic [2:0] idx, logic [31:0] val);
    cmd_t c;
    c = blank(KIND_MAP);
    c.map_index = idx; c.payload = val;
    push_cmd(c);
  endtask

  task automatic push_chunk(logic [7:0] ci, logic [7:0] off, logic [31:0] val);
    cmd_t c;
    c = blank(KIND_CHUNK);
    c.chunk_sel = ci; c.word_offset = off; c.payload = val;
    push_cmd(c);
    loaded_addrs.push_back({ci, off});
  endtask

  // A full upload; a broken one either repeats a chunk or leaves one pending.
  task automatic push_upload(bit broken);
    logic [31:0] map_val [MAP_WORDS];
    logic [7:0]  chunks[$];
    logic [7:0]  ci;
    int          n;
    int          flavor;
    push_cmd(blank(KIND_START));
    loaded_addrs.delete();
    foreach (map_val[i]) map_val[i] = 32'h0;
    n = $urandom_range(1, 3);
    while (chunks.size() < n) begin
      ci = 8'($urandom);
      if (!map_val[ci[7:5]][ci[4:0]]) begin
        map_val[ci[7:5]][ci[4:0]] = 1'b1;
        chunks.push_back(ci);
      end
    end
    for (int i = 0; i < MAP_WORDS; i++) push_map(3'(i), map_val[i]);
    flavor = $urandom_range(0, 1);
    foreach (chunks[k]) begin
      if (broken && flavor == 1 && k == 0) continue;
      push_chunk(chunks[k], 8'd0, $urandom);
      for (int o = 1; o <= $urandom_range(0, 3); o++) push_chunk(chunks[k], 8'(o), $urandom);
      if ($urandom_range(0, 2) == 0) push_chunk(chunks[k], 8'($urandom), $urandom);
    end
    if (broken && flavor == 0) push_chunk(chunks[0], 8'd0, $urandom);
    push_cmd(blank(KIND_END));
  endtask

  task automatic push_polls(int n, bit stall_first);
    logic [15:0] ia, da;
    for (int i = 0; i < n; i++) begin
      if (loaded_addrs.size() > 0 && $urandom_range(0, 3) != 0)
        ia = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
      else
        ia = 16'($urandom);
      case ($urandom_range(0, 3))
        0: da = 16'($urandom_range(0, 15));
        1: da = 16'($urandom);
        2: da = loaded_addrs.size() ? loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]
                                    : 16'(256);
        default: da = 16'($urandom_range(250, 260));
      endcase
      push_poll($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), ia, da, 8'($urandom),
                stall_first && i == 0);
    end
  endtask

  task automatic push_noise(int n);
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      c = cmd_t'({$urandom, $urandom, $urandom});
      if (c.kind == KIND_START) c.kind = KIND_POLL;
      push_cmd(c);
    end
  endtask

  // Sender.
  pending_t cur_item;
  bit       in_taken = 1'b0;
  bit       tx_burst = 1'b0;
  bit       draining = 1'b0;
  bit       long_stall_go = 1'b0;
  bit       long_stall_done = 1'b0;
  int       long_stall_cnt = 0;
  int       tx_gap = 0;
  int       drain_wait = 0;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_item(cur_item.c);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    logic v;
    v = in_tvalid;
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      v = 1'b0;
      if (draining) begin
        if (expected_beats.size() == 0) drain_wait--;
        if (drain_wait <= 0) draining = 1'b0;
      end else if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        if (cur_item.drain) begin
          draining = 1'b1;
          drain_wait = 40;
        end else begin
          v = 1'b1;
          in_tuser <= cur_item.c.kind;
          in_tdata <= {3'b0, cur_item.c.payload, cur_item.c.word_offset,
                       cur_item.c.chunk_sel, cur_item.c.map_index, cur_item.c.data_in,
                       cur_item.c.data_addr, cur_item.c.instr_addr, cur_item.c.hold,
                       cur_item.c.write_req};
          if (cur_item.big_stall) long_stall_go = 1'b1;
          if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
          tx_gap = (tx_burst || (long_stall_go && !long_stall_done)) ? 0
                                                                      : $urandom_range(0, 17);
        end
      end
    end
    in_tvalid <= v;
  end

  // Receiver.
  int rx_gap = 0;
  bit rx_burst = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_stall_go && !long_stall_done) begin
      long_stall_cnt++;
      if (long_stall_cnt >= LONG_STALL) long_stall_done = 1'b1;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      rx_gap = rx_burst ? 0 : $urandom_range(0, 17);
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat, kind", 32'(out_tuser), 32'h0);
      end else begin
        e = expected_beats.pop_front();
        if (out_tuser !== e.kind) report_mismatch("out_kind", 32'(out_tuser), 32'(e.kind));
        if (out_tdata[31:0] !== e.value) report_mismatch("out_value", out_tdata[31:0], e.value);
        if (out_tdata[34:32] !== e.index)
          report_mismatch("out_index", 32'(out_tdata[34:32]), 32'(e.index));
        if (out_tlast !== e.last) report_mismatch("last", 32'(out_tlast), 32'(e.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    foreach (data_mem[i]) data_mem[i] = 8'h0;
    foreach (chunk_pending[i]) chunk_pending[i] = 32'hFFFF_FFFF;
    prog_active = 1'b0; prog_valid = 1'b0; hold_prev = 1'b0; chunk_ok = 1'b0;
    data_shown = 8'h0; instr_shown = 32'h0;

    // Directed: write edges, out-of-range write, high reads, unused kinds,
    // an end with nothing uploaded, then a minimal upload at the chunk extremes.
    push_poll(1, 1, 16'hFFFF, 16'd0, 8'hA5);
    push_poll(1, 1, 16'h0000, 16'd0, 8'h5A);
    push_poll(1, 0, 16'h1234, 16'd255, 8'hFF);
    push_poll(1, 1, 16'h1234, 16'd255, 8'hFF);
    push_poll(0, 1, 16'h0000, 16'd256, 8'h77);
    push_poll(1, 1, 16'h0000, 16'hFFFF, 8'h12);
    for (int k = 5; k <= 7; k++) begin
      cmd_t c;
      c = cmd_t'({$urandom, $urandom, $urandom});
      c.kind = 3'(k);
      push_cmd(c);
    end
    push_map(3'd7, 32'h0);
    push_cmd(blank(KIND_END));
    push_cmd(blank(KIND_START));
    for (int i = 0; i < MAP_WORDS; i++)
      push_map(3'(i), (i == 0) ? 32'h1 : (i == 7) ? 32'h8000_0000 : 32'h0);
    push_chunk(8'd0, 8'd0, $urandom);
    push_chunk(8'd0, 8'd255, $urandom);
    push_chunk(8'd255, 8'd0, $urandom);
    push_chunk(8'd255, 8'd3, 32'hFFFF_FFFF);
    push_cmd(blank(KIND_END));
    push_drain();

    for (int r = 0; r < 3; r++) begin
      push_upload(r == 1);
      push_polls(20, r == 0);
      if (r == 1) push_drain();
    end
    push_noise(20);
    push_polls(10, 1'b0);

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_tvalid || draining || expected_beats.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
